/* rtl/sha_pkg.sv */
package sha_pkg;

    // One message word: a byte to absorb or a finish request.
    typedef struct packed {
        logic       action;
        logic [7:0] data_byte;
    } msg_t;

    // One digest word.
    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } dig_t;

    localparam int BLOCK_WORDS = 16;
    localparam int CHAIN_WORDS = 8;
    localparam int WORD_BITS   = 32;

    localparam logic        ACTION_ABSORB = 1'b0;
    localparam logic [7:0]  PAD_MARKER    = 8'h80;

    localparam logic [31:0] INIT_H [CHAIN_WORDS] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

    function automatic logic [31:0] big_sigma0(input logic [31:0] x);
        big_sigma0 = rotr(x, 2) ^ rotr(x, 13) ^ rotr(x, 22);
    endfunction

    function automatic logic [31:0] big_sigma1(input logic [31:0] x);
        big_sigma1 = rotr(x, 6) ^ rotr(x, 11) ^ rotr(x, 25);
    endfunction

    function automatic logic [31:0] small_sigma0(input logic [31:0] x);
        small_sigma0 = rotr(x, 7) ^ rotr(x, 18) ^ (x >> 3);
    endfunction

    function automatic logic [31:0] small_sigma1(input logic [31:0] x);
        small_sigma1 = rotr(x, 17) ^ rotr(x, 19) ^ (x >> 10);
    endfunction

endpackage

/* rtl/sha_ram.sv */
module sha_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Simple dual-port array with a registered read.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

/* rtl/sha256_byte_stream_hasher.sv */
// SHA-256 byte stream hasher.
// An absorb word is taken whenever the hasher is idle; the 64th byte of a block starts a
// compression through load, round and fold states, paced by the one-read-port memories.
// A finish pads one byte a cycle in the pad state, compresses once or twice, then gives eight
// digest words, each held while the receiver stalls.
// Reset clears the control state and brings the chain value back to the initial hash.
module sha256_byte_stream_hasher
    import sha_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic msg_valid,
    output logic msg_stall,
    input  msg_t msg,
    output logic dig_valid,
    input  logic dig_stall,
    output dig_t dig
);

    typedef enum logic [7:0] {
        ST_IDLE  = 8'b0000_0001,
        ST_PAD   = 8'b0000_0010,
        ST_LOAD  = 8'b0000_0100,
        ST_ROUND = 8'b0000_1000,
        ST_FOLD  = 8'b0001_0000,
        ST_ORD   = 8'b0010_0000,
        ST_OCAP  = 8'b0100_0000,
        ST_OWAIT = 8'b1000_0000
    } state_t;

    state_t        state_reg, state_next;
    logic [5:0]    pos_reg, pos_next;
    logic [60:0]   count_reg, count_next;
    logic [5:0]    step_reg, step_next;
    logic          marker_reg, marker_next;
    logic          lenph_reg, lenph_next;
    logic          finish_reg, finish_next;
    logic          done_reg, done_next;
    logic [7:0]    cvalid_reg, cvalid_next;
    logic          dvalid_reg, dvalid_next;
    logic          chit_reg;
    logic [2:0]    caddr_reg;

    logic [31:0]   asm_reg, asm_next;
    logic [63:0]   len_reg, len_next;
    logic [31:0]   v_reg [CHAIN_WORDS];
    logic [31:0]   v_next [CHAIN_WORDS];
    logic [31:0]   ws_reg [BLOCK_WORDS];
    logic [31:0]   ws_next [BLOCK_WORDS];
    dig_t          dig_reg, dig_next;

    logic          buf_we;
    logic [3:0]    buf_waddr;
    logic [31:0]   buf_wdata;
    logic [3:0]    buf_raddr;
    logic [31:0]   buf_rdata;
    logic          ch_we;
    logic [2:0]    ch_waddr;
    logic [31:0]   ch_wdata;
    logic [2:0]    ch_raddr;
    logic [31:0]   ch_rdata;
    logic [31:0]   chain_word;

    logic          push_en;
    logic [7:0]    push_byte;
    logic          is_len;
    logic [31:0]   t1;
    logic [31:0]   t2;

    // Block buffer, one 32-bit message word per entry.
    sha_ram #(.WIDTH(WORD_BITS), .DEPTH(BLOCK_WORDS)) u_buf (
        .clk   (clk),
        .we    (buf_we),
        .waddr (buf_waddr),
        .wdata (buf_wdata),
        .raddr (buf_raddr),
        .rdata (buf_rdata)
    );

    // Chain value; an entry not yet written reads as the initial hash.
    sha_ram #(.WIDTH(WORD_BITS), .DEPTH(CHAIN_WORDS)) u_chain (
        .clk   (clk),
        .we    (ch_we),
        .waddr (ch_waddr),
        .wdata (ch_wdata),
        .raddr (ch_raddr),
        .rdata (ch_rdata)
    );

    assign chain_word = chit_reg ? ch_rdata : INIT_H[caddr_reg];
    assign buf_raddr  = step_reg[3:0];
    assign ch_raddr   = step_reg[2:0];
    assign msg_stall  = (state_reg != ST_IDLE);
    assign dig_valid  = dvalid_reg;
    assign dig        = dig_reg;

    // Round datapath.
    assign t1 = v_reg[7] + big_sigma1(v_reg[4])
              + ((v_reg[4] & v_reg[5]) ^ (~v_reg[4] & v_reg[6]))
              + ROUND_K[step_reg] + ws_reg[0];
    assign t2 = big_sigma0(v_reg[0])
              + ((v_reg[0] & v_reg[1]) ^ (v_reg[0] & v_reg[2]) ^ (v_reg[1] & v_reg[2]));

    // Padding phase: length bytes start once the marker is in and position 56 is reached.
    assign is_len = marker_reg && (lenph_reg || (pos_reg == 6'd56));

    // Sequencer.
    always_comb
    begin
        state_next  = state_reg;
        pos_next    = pos_reg;
        count_next  = count_reg;
        step_next   = step_reg;
        marker_next = marker_reg;
        lenph_next  = lenph_reg;
        finish_next = finish_reg;
        done_next   = done_reg;
        cvalid_next = cvalid_reg;
        dvalid_next = dvalid_reg;
        asm_next    = asm_reg;
        len_next    = len_reg;
        v_next      = v_reg;
        ws_next     = ws_reg;
        dig_next    = dig_reg;
        buf_we      = 1'b0;
        buf_waddr   = pos_reg[5:2];
        buf_wdata   = asm_reg;
        ch_we       = 1'b0;
        ch_waddr    = 3'(step_reg - 6'd1);
        ch_wdata    = chain_word + v_reg[0];
        push_en     = 1'b0;
        push_byte   = msg.data_byte;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (msg_valid)
                begin
                    if (msg.action == ACTION_ABSORB)
                    begin
                        push_en    = 1'b1;
                        count_next = count_reg + 61'd1;
                    end
                    else
                    begin
                        finish_next = 1'b1;
                        len_next    = {count_reg, 3'b000};
                        state_next  = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                push_en = 1'b1;
                if (!marker_reg)
                begin
                    push_byte   = PAD_MARKER;
                    marker_next = 1'b1;
                end
                else if (is_len)
                begin
                    push_byte  = len_reg[8 * (7 - pos_reg[2:0]) +: 8];
                    lenph_next = 1'b1;
                end
                else
                begin
                    push_byte = 8'h00;
                end
            end
            ST_LOAD:
            begin
                if (step_reg != 6'd0)
                begin
                    for (int i = 0; i < BLOCK_WORDS - 1; i++)
                    begin
                        ws_next[i] = ws_reg[i + 1];
                    end
                    ws_next[BLOCK_WORDS - 1] = buf_rdata;
                    if (step_reg <= 6'd8)
                    begin
                        for (int i = 0; i < CHAIN_WORDS - 1; i++)
                        begin
                            v_next[i] = v_reg[i + 1];
                        end
                        v_next[CHAIN_WORDS - 1] = chain_word;
                    end
                end
                if (step_reg == 6'd16)
                begin
                    step_next  = 6'd0;
                    state_next = ST_ROUND;
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            ST_ROUND:
            begin
                for (int i = 0; i < BLOCK_WORDS - 1; i++)
                begin
                    ws_next[i] = ws_reg[i + 1];
                end
                ws_next[BLOCK_WORDS - 1] = ws_reg[0] + small_sigma0(ws_reg[1])
                                         + ws_reg[9] + small_sigma1(ws_reg[14]);
                v_next[7] = v_reg[6];
                v_next[6] = v_reg[5];
                v_next[5] = v_reg[4];
                v_next[4] = v_reg[3] + t1;
                v_next[3] = v_reg[2];
                v_next[2] = v_reg[1];
                v_next[1] = v_reg[0];
                v_next[0] = t1 + t2;
                if (step_reg == 6'd63)
                begin
                    step_next  = 6'd0;
                    state_next = ST_FOLD;
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            ST_FOLD:
            begin
                // Read word k while word k-1 is added and written back.
                if (step_reg != 6'd0)
                begin
                    ch_we = 1'b1;
                    cvalid_next[ch_waddr] = 1'b1;
                    for (int i = 0; i < CHAIN_WORDS - 1; i++)
                    begin
                        v_next[i] = v_reg[i + 1];
                    end
                    v_next[CHAIN_WORDS - 1] = v_reg[0];
                end
                if (step_reg == 6'd8)
                begin
                    step_next = 6'd0;
                    if (done_reg)
                    begin
                        state_next = ST_ORD;
                    end
                    else if (finish_reg)
                    begin
                        state_next = ST_PAD;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
                else
                begin
                    step_next = step_reg + 6'd1;
                end
            end
            ST_ORD:
            begin
                state_next = ST_OCAP;
            end
            ST_OCAP:
            begin
                dig_next.digest_word = chain_word;
                dig_next.word_index  = step_reg[2:0];
                dig_next.last_word   = (step_reg[2:0] == 3'd7);
                dvalid_next          = 1'b1;
                state_next           = ST_OWAIT;
            end
            ST_OWAIT:
            begin
                if (!dig_stall)
                begin
                    dvalid_next = 1'b0;
                    if (step_reg[2:0] == 3'd7)
                    begin
                        step_next   = 6'd0;
                        pos_next    = 6'd0;
                        count_next  = 61'd0;
                        marker_next = 1'b0;
                        lenph_next  = 1'b0;
                        finish_next = 1'b0;
                        done_next   = 1'b0;
                        cvalid_next = 8'd0;
                        state_next  = ST_IDLE;
                    end
                    else
                    begin
                        step_next  = step_reg + 6'd1;
                        state_next = ST_ORD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        // Byte insertion; a full word goes to the buffer, a full block starts a compression.
        if (push_en)
        begin
            asm_next[8 * (3 - pos_reg[1:0]) +: 8] = push_byte;
            buf_wdata = asm_next;
            buf_we    = (pos_reg[1:0] == 2'd3);
            pos_next  = pos_reg + 6'd1;
            if (pos_reg == 6'd63)
            begin
                step_next  = 6'd0;
                state_next = ST_LOAD;
                done_next  = (state_reg == ST_PAD) && is_len;
            end
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            pos_reg    <= 6'd0;
            count_reg  <= 61'd0;
            step_reg   <= 6'd0;
            marker_reg <= 1'b0;
            lenph_reg  <= 1'b0;
            finish_reg <= 1'b0;
            done_reg   <= 1'b0;
            cvalid_reg <= 8'd0;
            dvalid_reg <= 1'b0;
            chit_reg   <= 1'b0;
            caddr_reg  <= 3'd0;
        end
        else
        begin
            state_reg  <= state_next;
            pos_reg    <= pos_next;
            count_reg  <= count_next;
            step_reg   <= step_next;
            marker_reg <= marker_next;
            lenph_reg  <= lenph_next;
            finish_reg <= finish_next;
            done_reg   <= done_next;
            cvalid_reg <= cvalid_next;
            dvalid_reg <= dvalid_next;
            chit_reg   <= cvalid_reg[ch_raddr];
            caddr_reg  <= ch_raddr;
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        asm_reg <= asm_next;
        len_reg <= len_next;
        v_reg   <= v_next;
        ws_reg  <= ws_next;
        dig_reg <= dig_next;
    end

endmodule
